[rtl/core/tensor_permute_index_remap_core_macros.svh]
// Assertion macros for the tensor permute index remap core.
// Expects aclk and aresetn in the scope of use.
`ifndef TENSOR_PERMUTE_INDEX_REMAP_CORE_MACROS_SVH
`define TENSOR_PERMUTE_INDEX_REMAP_CORE_MACROS_SVH

// same-cycle implication
`define TPIR_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define TPIR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/tpir_pkg.sv]
// Shared types, constants and configuration decode for the permute index remap core.
// No dependencies.
package tpir_pkg;

    localparam int MaxRank     = 4;
    localparam int DimSizeBits = 12;
    localparam int SizeW       = DimSizeBits + 1;
    localparam int IdxW        = 48;
    localparam int ElemW       = 64;
    localparam int ErrW        = 2;
    localparam int RankW       = 3;
    localparam int PermW       = 8;
    localparam int CfgW        = 13;
    localparam int CfgIdxW     = 3;

    localparam logic [ErrW-1:0] ErrNone  = 2'd0;
    localparam logic [ErrW-1:0] ErrRange = 2'd1;
    localparam logic [ErrW-1:0] ErrPerm  = 2'd2;

    localparam logic [CfgIdxW-1:0] CfgRank  = 3'd0;
    localparam logic [CfgIdxW-1:0] CfgSize0 = 3'd1;
    localparam logic [CfgIdxW-1:0] CfgSize1 = 3'd2;
    localparam logic [CfgIdxW-1:0] CfgSize2 = 3'd3;
    localparam logic [CfgIdxW-1:0] CfgSize3 = 3'd4;
    localparam logic [CfgIdxW-1:0] CfgPerm  = 3'd5;

    typedef logic [SizeW-1:0]       size_t;
    typedef logic [DimSizeBits-1:0] crd_t;
    typedef logic [1:0]             dim_t;

    // Shape padded to MaxRank with leading unit dimensions.
    typedef struct packed {
        size_t [MaxRank-1:0] sz;
        dim_t  [MaxRank-1:0] pm;
        logic                perm_bad;
    } cfg_t;

    typedef struct packed {
        logic [ElemW-1:0]   elem;
        logic [ErrW-1:0]    err;
        crd_t [MaxRank-1:0] crd;
    } side_t;

    function automatic cfg_t derive_cfg(input logic [RankW-1:0] rank,
                                        input size_t [MaxRank-1:0] size_in,
                                        input logic [PermW-1:0] perm);
        cfg_t               c;
        logic [RankW-1:0]   r;
        logic [RankW-1:0]   off;
        logic [MaxRank-1:0] used;
        dim_t               p;
        size_t              s;
        logic [RankW-1:0]   pos;
        r = rank;
        if (r == '0) r = RankW'(1);
        if (r > RankW'(MaxRank)) r = RankW'(MaxRank);
        off = RankW'(MaxRank) - r;
        used = '0;
        c.perm_bad = 1'b0;
        for (int k = 0; k < MaxRank; k++) begin
            c.sz[k] = size_t'(1);
            c.pm[k] = dim_t'(k);
        end
        for (int k = 0; k < MaxRank; k++) begin
            if (RankW'(k) < r) begin
                p = perm[2*k +: 2];
                if ({1'b0, p} >= r || used[p]) c.perm_bad = 1'b1;
                else used[p] = 1'b1;
                s = size_in[k];
                if (s > size_t'(1 << DimSizeBits)) s = size_t'(1 << DimSizeBits);
                pos = RankW'(k) + off;
                c.sz[pos[1:0]] = s;
                c.pm[pos[1:0]] = dim_t'(RankW'(p) + off);
            end
        end
        return c;
    endfunction

endpackage

[rtl/core/tensor_permute_index_remap_core.sv]
// Permuted-axis address generator for row-major N-D tensors: top level.
// Uses tpir_pkg, tpir_check, tpir_div, tpir_merge and the assertion macros.
//
// Input channel s_*: one item is a source linear index and a 64-bit element.
// Result channel m_*: the destination linear index in the permuted tensor, the
// element unchanged and an error code (index out of range, or a bad
// permutation code, which takes precedence; dst is zero on error).
// Configuration: cfg_we/cfg_index/cfg_wdata write rank, the four source
// extents and the permutation code; write only while no item is in flight.
// Throughput: one item per cycle while the receiver does not stall. The path
// from acceptance to the result being offered runs through 3 check stages,
// three 48-stage bit-serial dividers that split the index into coordinates,
// 3 multiply-add stages and the output register.
// When the receiver stalls with a result waiting, the whole pipeline holds and
// s_ready drops; nothing is lost or repeated.
// Reset clears all valid bits and loads rank 1, unit extents, identity order.
module tensor_permute_index_remap_core import tpir_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_we,
    input  logic [CfgIdxW-1:0] cfg_index,
    input  logic [CfgW-1:0]    cfg_wdata,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [IdxW-1:0]    s_src_index,
    input  logic [ElemW-1:0]   s_element,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [IdxW-1:0]    m_dst_index,
    output logic [ElemW-1:0]   m_element_out,
    output logic [ErrW-1:0]    m_error_code
);

`include "tensor_permute_index_remap_core_macros.svh"

    logic [RankW-1:0]    rank_reg;
    size_t [MaxRank-1:0] size_reg;
    logic [PermW-1:0]    perm_reg;
    cfg_t                cfg;
    logic                en;

    logic            ck_valid;
    logic [IdxW-1:0] ck_idx;
    side_t           ck_side;

    logic            d1_valid, d2_valid, d3_valid;
    logic [IdxW-1:0] d1_quo, d2_quo, d3_quo;
    crd_t            d1_rem, d2_rem, d3_rem;
    side_t           d1_side, d2_side, d3_side;
    side_t           d2_in_side, d3_in_side, mg_in_side;

    logic             mg_valid;
    logic [IdxW-1:0]  mg_dst;
    logic [ElemW-1:0] mg_elem;
    logic [ErrW-1:0]  mg_err;

    logic             m_valid_reg;
    logic [IdxW-1:0]  dst_reg;
    logic [ElemW-1:0] elem_reg;
    logic [ErrW-1:0]  err_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rank_reg <= RankW'(1);
            size_reg <= {MaxRank{size_t'(1)}};
            perm_reg <= PermW'(228);
        end else if (cfg_we) begin
            unique case (cfg_index)
                CfgRank:  rank_reg    <= cfg_wdata[RankW-1:0];
                CfgSize0: size_reg[0] <= cfg_wdata[SizeW-1:0];
                CfgSize1: size_reg[1] <= cfg_wdata[SizeW-1:0];
                CfgSize2: size_reg[2] <= cfg_wdata[SizeW-1:0];
                CfgSize3: size_reg[3] <= cfg_wdata[SizeW-1:0];
                CfgPerm:  perm_reg    <= cfg_wdata[PermW-1:0];
                default: ;
            endcase
        end
    end

    assign cfg     = derive_cfg(rank_reg, size_reg, perm_reg);
    assign en      = !m_valid_reg || m_ready;
    assign s_ready = en;

    tpir_check u_check (
        .aclk(aclk), .aresetn(aresetn), .en(en), .cfg(cfg),
        .in_valid(s_valid && s_ready), .in_idx(s_src_index), .in_elem(s_element),
        .out_valid(ck_valid), .out_idx(ck_idx), .out_side(ck_side)
    );

    tpir_div u_div3 (
        .aclk(aclk), .aresetn(aresetn), .en(en), .divisor(cfg.sz[3]),
        .in_valid(ck_valid), .in_num(ck_idx), .in_side(ck_side),
        .out_valid(d1_valid), .out_quo(d1_quo), .out_rem(d1_rem), .out_side(d1_side)
    );

    always_comb begin
        d2_in_side        = d1_side;
        d2_in_side.crd[3] = d1_rem;
    end

    tpir_div u_div2 (
        .aclk(aclk), .aresetn(aresetn), .en(en), .divisor(cfg.sz[2]),
        .in_valid(d1_valid), .in_num(d1_quo), .in_side(d2_in_side),
        .out_valid(d2_valid), .out_quo(d2_quo), .out_rem(d2_rem), .out_side(d2_side)
    );

    always_comb begin
        d3_in_side        = d2_side;
        d3_in_side.crd[2] = d2_rem;
    end

    tpir_div u_div1 (
        .aclk(aclk), .aresetn(aresetn), .en(en), .divisor(cfg.sz[1]),
        .in_valid(d2_valid), .in_num(d2_quo), .in_side(d3_in_side),
        .out_valid(d3_valid), .out_quo(d3_quo), .out_rem(d3_rem), .out_side(d3_side)
    );

    always_comb begin
        mg_in_side        = d3_side;
        mg_in_side.crd[1] = d3_rem;
        mg_in_side.crd[0] = d3_quo[DimSizeBits-1:0];
    end

    tpir_merge u_merge (
        .aclk(aclk), .aresetn(aresetn), .en(en), .cfg(cfg),
        .in_valid(d3_valid), .in_side(mg_in_side),
        .out_valid(mg_valid), .out_dst(mg_dst), .out_elem(mg_elem), .out_err(mg_err)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= mg_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            dst_reg  <= mg_dst;
            elem_reg <= mg_elem;
            err_reg  <= mg_err;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_dst_index   = dst_reg;
    assign m_element_out = elem_reg;
    assign m_error_code  = err_reg;

    `TPIR_ASSERT_IMPL(a_err_zero_dst, m_valid && m_error_code != ErrNone, m_dst_index == '0, "error result with nonzero index")
    `TPIR_ASSERT_IMPL(a_bad_perm, m_valid && cfg.perm_bad, m_error_code == ErrPerm, "bad permutation not flagged")
    `TPIR_ASSERT_NEXT(a_drain, m_valid_reg && m_ready && !mg_valid, !m_valid, "result repeated after drain")

endmodule

[rtl/core/tpir_check.sv]
// Front stages: element count of the shape and the range and permutation check.
// Depends on tpir_pkg.
module tpir_check import tpir_pkg::*; (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            en,
    input  cfg_t            cfg,
    input  logic            in_valid,
    input  logic [IdxW-1:0] in_idx,
    input  logic [ElemW-1:0] in_elem,
    output logic            out_valid,
    output logic [IdxW-1:0] out_idx,
    output side_t           out_side
);

    localparam int PW = 2 * SizeW;
    localparam int CW = 4 * SizeW;

    logic             v1_reg, v2_reg, v3_reg;
    logic [IdxW-1:0]  idx1_reg, idx2_reg, idx3_reg;
    logic [ElemW-1:0] elem1_reg, elem2_reg;
    logic [PW-1:0]    p01_reg, p23_reg, p01_next, p23_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic [ErrW-1:0]  err_next;
    side_t            side3_reg;

    assign p01_next = PW'(cfg.sz[0]) * PW'(cfg.sz[1]);
    assign p23_next = PW'(cfg.sz[2]) * PW'(cfg.sz[3]);
    assign cnt_next = CW'(p01_reg) * CW'(p23_reg);

    always_comb begin
        if (cfg.perm_bad) err_next = ErrPerm;
        else if (CW'(idx2_reg) >= cnt_reg) err_next = ErrRange;
        else err_next = ErrNone;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            idx1_reg       <= in_idx;
            elem1_reg      <= in_elem;
            p01_reg        <= p01_next;
            p23_reg        <= p23_next;
            idx2_reg       <= idx1_reg;
            elem2_reg      <= elem1_reg;
            cnt_reg        <= cnt_next;
            idx3_reg       <= idx2_reg;
            side3_reg.elem <= elem2_reg;
            side3_reg.err  <= err_next;
            side3_reg.crd  <= '0;
        end
    end

    assign out_valid = v3_reg;
    assign out_idx   = idx3_reg;
    assign out_side  = side3_reg;

endmodule

[rtl/core/tpir_div.sv]
// Bit-per-stage restoring divider, one quotient bit per register stage.
// Carries item sideband alongside. Depends on tpir_pkg.
module tpir_div import tpir_pkg::*; (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            en,
    input  size_t           divisor,
    input  logic            in_valid,
    input  logic [IdxW-1:0] in_num,
    input  side_t           in_side,
    output logic            out_valid,
    output logic [IdxW-1:0] out_quo,
    output crd_t            out_rem,
    output side_t           out_side
);

    logic            v_reg [IdxW];
    logic [IdxW-1:0] q_reg [IdxW];
    crd_t            r_reg [IdxW];
    side_t           s_reg [IdxW];

    for (genvar k = 0; k < IdxW; k++) begin : g_step
        logic            v_prev;
        logic [IdxW-1:0] q_prev;
        crd_t            r_prev;
        side_t           s_prev;
        logic [SizeW-1:0] trial;
        logic            ge;
        logic [IdxW-1:0] q_next;
        crd_t            r_next;

        if (k == 0) begin : g_first
            assign v_prev = in_valid;
            assign q_prev = in_num;
            assign r_prev = '0;
            assign s_prev = in_side;
        end else begin : g_rest
            assign v_prev = v_reg[k-1];
            assign q_prev = q_reg[k-1];
            assign r_prev = r_reg[k-1];
            assign s_prev = s_reg[k-1];
        end

        assign trial  = {r_prev, q_prev[IdxW-1]};
        assign ge     = trial >= divisor;
        assign q_next = {q_prev[IdxW-2:0], ge};
        assign r_next = ge ? crd_t'(trial - divisor) : crd_t'(trial);

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[k] <= 1'b0;
            end else if (en) begin
                v_reg[k] <= v_prev;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                q_reg[k] <= q_next;
                r_reg[k] <= r_next;
                s_reg[k] <= s_prev;
            end
        end
    end

    assign out_valid = v_reg[IdxW-1];
    assign out_quo   = q_reg[IdxW-1];
    assign out_rem   = r_reg[IdxW-1];
    assign out_side  = s_reg[IdxW-1];

endmodule

[rtl/core/tpir_merge.sv]
// Recombines coordinates with the permuted shape, one multiply-add per stage.
// Depends on tpir_pkg.
module tpir_merge import tpir_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             en,
    input  cfg_t             cfg,
    input  logic             in_valid,
    input  side_t            in_side,
    output logic             out_valid,
    output logic [IdxW-1:0]  out_dst,
    output logic [ElemW-1:0] out_elem,
    output logic [ErrW-1:0]  out_err
);

    localparam int A1W = 2 * SizeW;
    localparam int A2W = 3 * SizeW + 1;
    localparam int A3W = 4 * SizeW + 1;

    logic            v1_reg, v2_reg, v3_reg;
    logic [A1W-1:0]  a1_reg, a1_next;
    logic [A2W-1:0]  a2_reg, a2_next;
    logic [A3W-1:0]  a3_next;
    logic [IdxW-1:0] dst_reg;
    side_t           s1_reg, s2_reg;
    logic [ElemW-1:0] elem_reg;
    logic [ErrW-1:0] err_reg;

    assign a1_next = A1W'(in_side.crd[cfg.pm[0]]) * A1W'(cfg.sz[cfg.pm[1]])
                   + A1W'(in_side.crd[cfg.pm[1]]);
    assign a2_next = A2W'(a1_reg) * A2W'(cfg.sz[cfg.pm[2]]) + A2W'(s1_reg.crd[cfg.pm[2]]);
    assign a3_next = A3W'(a2_reg) * A3W'(cfg.sz[cfg.pm[3]]) + A3W'(s2_reg.crd[cfg.pm[3]]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            a1_reg   <= a1_next;
            s1_reg   <= in_side;
            a2_reg   <= a2_next;
            s2_reg   <= s1_reg;
            dst_reg  <= (s2_reg.err != ErrNone) ? '0 : a3_next[IdxW-1:0];
            elem_reg <= s2_reg.elem;
            err_reg  <= s2_reg.err;
        end
    end

    assign out_valid = v3_reg;
    assign out_dst   = dst_reg;
    assign out_elem  = elem_reg;
    assign out_err   = err_reg;

endmodule
